[rtl/cki_pkg.sv]
// Shared types and constants for the camera keyframe interpolator.
// Holds field widths, fixed-point constants and the square root pipeline geometry.
// No dependencies.
`default_nettype none

package cki_pkg;

   // Field widths of the keyframe and result items
   localparam int LAT_W  = 24;
   localparam int LON_W  = 25;
   localparam int BRG_W  = 25;
   localparam int TILT_W = 23;
   localparam int ZOOM_W = 21;
   localparam int FRAC_W = 17;

   // Stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = 256;
   localparam int RSP_DATA_W = 120;

   // Fixed-point constants: Q1.16 fraction and angles in 1/65536 degree
   localparam int ONE_Q16  = 65536;
   localparam int HALF_Q16 = 32768;
   localparam int DEG180   = 11796480;
   localparam int DEG360   = 23592960;

   // Square root of a 34-bit radicand, 17 iterations spread over the stages
   localparam int SQRT_W         = 34;
   localparam int ROOT_W         = 17;
   localparam int SQRT_ITERS     = 17;
   localparam int SQRT_PER_STAGE = 3;
   localparam int SQRT_STAGES    = (SQRT_ITERS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

   // Input item as packed on req_tdata, first field in the lowest bits
   typedef struct packed {
      logic [2:0]               pad;
      logic [FRAC_W-1:0]        fraction;
      logic [ZOOM_W-1:0]        to_zoom;
      logic [TILT_W-1:0]        to_tilt;
      logic [BRG_W-1:0]         to_bearing;
      logic signed [LON_W-1:0]  to_longitude;
      logic signed [LAT_W-1:0]  to_latitude;
      logic [ZOOM_W-1:0]        from_zoom;
      logic [TILT_W-1:0]        from_tilt;
      logic [BRG_W-1:0]         from_bearing;
      logic signed [LON_W-1:0]  from_longitude;
      logic signed [LAT_W-1:0]  from_latitude;
   } req_fields_type;

   // Result item as packed on rsp_tdata, first field in the lowest bits
   typedef struct packed {
      logic [1:0]               pad;
      logic [ZOOM_W-1:0]        out_zoom;
      logic [TILT_W-1:0]        out_tilt;
      logic [BRG_W-1:0]         out_bearing;
      logic signed [LON_W-1:0]  out_longitude;
      logic signed [LAT_W-1:0]  out_latitude;
   } rsp_fields_type;

endpackage

`default_nettype wire

[rtl/cki_sqrt.sv]
// Pipelined square root for the zoom-in position fraction.
// Restoring digit-by-digit method, a few iterations per register stage.
// Depends on cki_pkg.
`default_nettype none

module cki_sqrt
   import cki_pkg::*;
(
   input  logic              clock,
   input  logic              enable,
   input  logic [SQRT_W-1:0] radicand,
   output logic [ROOT_W-1:0] root
);

   logic [SQRT_W-1:0] rem_ff  [SQRT_STAGES];
   logic [SQRT_W-1:0] acc_ff  [SQRT_STAGES];
   logic [SQRT_W-1:0] rem_in  [SQRT_STAGES];
   logic [SQRT_W-1:0] acc_in  [SQRT_STAGES];
   logic [SQRT_W-1:0] src_rem [SQRT_STAGES];
   logic [SQRT_W-1:0] src_acc [SQRT_STAGES];

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign src_rem[s] = radicand;
         assign src_acc[s] = '0;
      end else begin : g_next
         assign src_rem[s] = rem_ff[s-1];
         assign src_acc[s] = acc_ff[s-1];
      end

      always_comb begin
         logic [SQRT_W-1:0] x;
         logic [SQRT_W-1:0] r;
         logic [SQRT_W-1:0] bitv;
         logic [SQRT_W-1:0] trial;
         x     = src_rem[s];
         r     = src_acc[s];
         bitv  = '0;
         trial = '0;
         for (int j = 0; j < SQRT_PER_STAGE; j++) begin
            if (s * SQRT_PER_STAGE + j < SQRT_ITERS) begin
               bitv  = SQRT_W'(1) << (2 * (SQRT_ITERS - 1 - (s * SQRT_PER_STAGE + j)));
               trial = r + bitv;
               if (x >= trial) begin
                  x = x - trial;
                  r = (r >> 1) + bitv;
               end else begin
                  r = r >> 1;
               end
            end
         end
         rem_in[s] = x;
         acc_in[s] = r;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= rem_in[s];
            acc_ff[s] <= acc_in[s];
         end
      end
   end

   // Round to nearest: step up when the remainder exceeds the root.
   assign root = ROOT_W'(acc_ff[SQRT_STAGES-1]
                 + SQRT_W'(rem_ff[SQRT_STAGES-1] > acc_ff[SQRT_STAGES-1]));

endmodule

`default_nettype wire

[rtl/camera_keyframe_interpolator.sv]
// Camera keyframe interpolator: eased interpolation between two camera keyframes.
// Top level with the stream ports, the main pipeline and the output skid register.
// Depends on cki_pkg and cki_sqrt.
//
// Usage: each req item carries a start keyframe, an end keyframe and a progress
// fraction t in Q1.16; each rsp item carries the camera state at t. Angles are in
// 1/65536 degree and zoom in 1/65536 level. The block keeps no state between items,
// so every req item gives exactly one rsp item, in order.
// Stages from acceptance to rsp_tvalid: two for the ease curve,
// six for the square root used when zooming in, one to pick the position fraction,
// one for the five multiplications and one for the sums and angle wrap.
// Throughput is one item per clock while rsp_tready stays high.
// When the receiver stalls, the item leaving the last stage is parked in a skid
// register and the whole pipeline then holds until that item has been taken, so
// nothing is lost or repeated; req_tready comes from a register, not from rsp_tready.
// A synchronous reset clears all valid bits, the skid register's among them; payload
// registers, the skid register's included, are not reset.
`default_nettype none

module camera_keyframe_interpolator
   import cki_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // from_latitude, from_longitude, from_bearing, from_tilt, from_zoom, to_latitude,
   // to_longitude, to_bearing, to_tilt, to_zoom, fraction, zero padding
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_latitude, out_longitude, out_bearing, out_tilt, out_zoom, zero padding
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int PIPE_DEPTH = SQRT_STAGES + 5;
   localparam int LAST       = PIPE_DEPTH - 1;
   localparam int SEL_STAGE  = SQRT_STAGES + 2;
   localparam int SUM_W      = 27;
   localparam int PROD_W     = 43;
   localparam logic [FRAC_W-1:0] ONE_FRAC  = FRAC_W'(ONE_Q16);
   localparam logic [FRAC_W-1:0] HALF_FRAC = FRAC_W'(HALF_Q16);

   // Start values and differences that travel with the item
   typedef struct packed {
      logic signed [LAT_W-1:0]  flat;
      logic signed [LAT_W:0]    dlat;
      logic signed [LON_W-1:0]  flon;
      logic signed [LON_W-1:0]  dlon;
      logic [BRG_W-1:0]         fbr;
      logic signed [BRG_W-1:0]  dbr;
      logic [TILT_W-1:0]        ftl;
      logic signed [TILT_W:0]   dtl;
      logic [ZOOM_W-1:0]        fzm;
      logic signed [ZOOM_W:0]   dz;
      logic                     zoom_in;
      logic                     zoom_out;
   } geo_type;

   typedef struct packed {
      geo_type            geo;
      logic [FRAC_W-1:0]  e;
      logic [FRAC_W-1:0]  esq;
   } mid_type;

   // Rounds a Q16 product half toward plus infinity.
   function automatic logic signed [SUM_W-1:0] round_q16(input logic signed [PROD_W-1:0] prod);
      logic signed [PROD_W-1:0] biased;
      biased    = prod + PROD_W'(HALF_Q16);
      round_q16 = SUM_W'(biased >>> 16);
   endfunction

   req_fields_type req_view;
   assign req_view = req_fields_type'(req_tdata);

   // Pipeline control: the pipeline advances whenever the skid register is empty.
   logic                  skid_valid_ff;
   logic                  pipe_en;
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;

   assign pipe_en    = !skid_valid_ff;
   assign req_tready = pipe_en;
   assign valid_in   = {valid_ff[PIPE_DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: saturate t, fold it about one half for the ease square, and take the
   // differences. Longitude and bearing differences are wrapped to the short way.
   logic [FRAC_W-1:0]        t_sat;
   logic                     hi_in;
   logic [15:0]              w_in;
   logic [31:0]              sqw_in;
   logic signed [SUM_W-1:0]  dlon_raw;
   logic signed [SUM_W-1:0]  dbr_raw;
   logic signed [SUM_W-1:0]  dlon_wrap;
   logic signed [SUM_W-1:0]  dbr_wrap;
   geo_type                  geo1_in;

   always_comb begin
      t_sat  = (req_view.fraction > ONE_FRAC) ? ONE_FRAC : req_view.fraction;
      hi_in  = t_sat >= HALF_FRAC;
      w_in   = hi_in ? 16'(ONE_FRAC - t_sat) : 16'(t_sat);
      sqw_in = 32'(w_in) * 32'(w_in);

      dlon_raw = SUM_W'(req_view.to_longitude) - SUM_W'(req_view.from_longitude);
      if (dlon_raw > DEG180) begin
         dlon_wrap = SUM_W'(dlon_raw - DEG360);
      end else if (dlon_raw < -DEG180) begin
         dlon_wrap = SUM_W'(dlon_raw + DEG360);
      end else begin
         dlon_wrap = dlon_raw;
      end

      dbr_raw = $signed(SUM_W'(req_view.to_bearing)) - $signed(SUM_W'(req_view.from_bearing));
      if (dbr_raw > DEG180) begin
         dbr_wrap = SUM_W'(dbr_raw - DEG360);
      end else if (dbr_raw < -DEG180) begin
         dbr_wrap = SUM_W'(dbr_raw + DEG360);
      end else begin
         dbr_wrap = dbr_raw;
      end

      geo1_in.flat     = req_view.from_latitude;
      geo1_in.dlat     = (LAT_W+1)'(req_view.to_latitude) - (LAT_W+1)'(req_view.from_latitude);
      geo1_in.flon     = req_view.from_longitude;
      geo1_in.dlon     = LON_W'(dlon_wrap);
      geo1_in.fbr      = req_view.from_bearing;
      geo1_in.dbr      = BRG_W'(dbr_wrap);
      geo1_in.ftl      = req_view.from_tilt;
      geo1_in.dtl      = $signed((TILT_W+1)'(req_view.to_tilt))
                         - $signed((TILT_W+1)'(req_view.from_tilt));
      geo1_in.fzm      = req_view.from_zoom;
      geo1_in.dz       = $signed((ZOOM_W+1)'(req_view.to_zoom))
                         - $signed((ZOOM_W+1)'(req_view.from_zoom));
      geo1_in.zoom_in  = geo1_in.dz > ONE_Q16;
      geo1_in.zoom_out = geo1_in.dz < -ONE_Q16;
   end

   geo_type      geo1_ff;
   logic [31:0]  sqw_ff;
   logic         hi_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         geo1_ff <= geo1_in;
         sqw_ff  <= sqw_in;
         hi_ff   <= hi_in;
      end
   end

   // Stage 2: the eased fraction e. Below one half it is twice the square, rounded;
   // from one half up, one minus twice the square of the folded fraction, rounded.
   logic [30:0]        sq_round;
   logic [FRAC_W-1:0]  sq_in;
   logic [FRAC_W-1:0]  e_in;
   geo_type            geo2_ff;
   logic [FRAC_W-1:0]  e2_ff;

   assign sq_round = 31'(sqw_ff) + 31'(16384);
   assign sq_in    = FRAC_W'(sq_round >> 15);
   assign e_in     = hi_ff ? ONE_FRAC - sq_in : sq_in;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         geo2_ff <= geo1_ff;
         e2_ff   <= e_in;
      end
   end

   // Stages 3 to 8: the square root of e runs alongside; e squared is formed in the
   // first of these stages and carried with the item.
   logic [SQRT_W-1:0]  esq_prod;
   logic [FRAC_W-1:0]  esq_in;
   logic [ROOT_W-1:0]  root;
   mid_type            mid_ff [SQRT_STAGES];

   assign esq_prod = SQRT_W'(e2_ff) * SQRT_W'(e2_ff) + SQRT_W'(HALF_Q16);
   assign esq_in   = FRAC_W'(esq_prod >> 16);

   cki_sqrt u_sqrt (
      .clock    (clock),
      .enable   (pipe_en),
      .radicand (SQRT_W'({e2_ff, 16'h0000})),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mid_ff[0] <= '{geo: geo2_ff, e: e2_ff, esq: esq_in};
         for (int k = 1; k < SQRT_STAGES; k++) begin
            mid_ff[k] <= mid_ff[k-1];
         end
      end
   end

   // Stage 9: position fraction p. Zooming in by more than one level uses sqrt(e),
   // zooming out by more than one level uses e squared, otherwise e.
   logic [FRAC_W-1:0]  p_in;
   geo_type            geo9_ff;
   logic [FRAC_W-1:0]  e9_ff;
   logic [FRAC_W-1:0]  p9_ff;

   always_comb begin
      if (mid_ff[SQRT_STAGES-1].geo.zoom_in) begin
         p_in = FRAC_W'(root);
      end else if (mid_ff[SQRT_STAGES-1].geo.zoom_out) begin
         p_in = mid_ff[SQRT_STAGES-1].esq;
      end else begin
         p_in = mid_ff[SQRT_STAGES-1].e;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         geo9_ff <= mid_ff[SQRT_STAGES-1].geo;
         e9_ff   <= mid_ff[SQRT_STAGES-1].e;
         p9_ff   <= p_in;
      end
   end

   // Stage 10: the five scaled steps. Latitude and longitude use p, the rest use e.
   logic signed [FRAC_W:0]    p_s;
   logic signed [FRAC_W:0]    e_s;
   logic signed [PROD_W-1:0]  plat_ff;
   logic signed [PROD_W-1:0]  plon_ff;
   logic signed [PROD_W-1:0]  pbr_ff;
   logic signed [PROD_W-1:0]  ptl_ff;
   logic signed [PROD_W-1:0]  pzm_ff;
   geo_type                   geo10_ff;

   assign p_s = $signed({1'b0, p9_ff});
   assign e_s = $signed({1'b0, e9_ff});

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         plat_ff  <= PROD_W'(geo9_ff.dlat) * PROD_W'(p_s);
         plon_ff  <= PROD_W'(geo9_ff.dlon) * PROD_W'(p_s);
         pbr_ff   <= PROD_W'(geo9_ff.dbr) * PROD_W'(e_s);
         ptl_ff   <= PROD_W'(geo9_ff.dtl) * PROD_W'(e_s);
         pzm_ff   <= PROD_W'(geo9_ff.dz) * PROD_W'(e_s);
         geo10_ff <= geo9_ff;
      end
   end

   // Stage 11: add the steps to the start values. Longitude is brought back into
   // plus or minus 180 degrees and bearing into 0 to under 360; one correction
   // suffices for every input pattern.
   logic signed [SUM_W-1:0]  lat_sum;
   logic signed [SUM_W-1:0]  lon_sum;
   logic signed [SUM_W-1:0]  lon_norm;
   logic signed [SUM_W-1:0]  br_sum;
   logic signed [SUM_W-1:0]  br_norm;
   logic signed [SUM_W-1:0]  tl_sum;
   logic signed [SUM_W-1:0]  zm_sum;
   rsp_fields_type           out_in;
   rsp_fields_type           out_ff;

   always_comb begin
      lat_sum = SUM_W'(geo10_ff.flat) + round_q16(plat_ff);
      lon_sum = SUM_W'(geo10_ff.flon) + round_q16(plon_ff);
      br_sum  = $signed(SUM_W'(geo10_ff.fbr)) + round_q16(pbr_ff);
      tl_sum  = $signed(SUM_W'(geo10_ff.ftl)) + round_q16(ptl_ff);
      zm_sum  = $signed(SUM_W'(geo10_ff.fzm)) + round_q16(pzm_ff);

      if (lon_sum > DEG180) begin
         lon_norm = SUM_W'(lon_sum - DEG360);
      end else if (lon_sum < -DEG180) begin
         lon_norm = SUM_W'(lon_sum + DEG360);
      end else begin
         lon_norm = lon_sum;
      end

      if (br_sum >= DEG360) begin
         br_norm = SUM_W'(br_sum - DEG360);
      end else if (br_sum < 0) begin
         br_norm = SUM_W'(br_sum + DEG360);
      end else begin
         br_norm = br_sum;
      end

      out_in.pad           = '0;
      out_in.out_latitude  = LAT_W'(lat_sum);
      out_in.out_longitude = LON_W'(lon_norm);
      out_in.out_bearing   = BRG_W'(br_norm);
      out_in.out_tilt      = TILT_W'(tl_sum);
      out_in.out_zoom      = ZOOM_W'(zm_sum);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         out_ff <= out_in;
      end
   end

   // Skid register: catches the last stage's item when the receiver stalls, and the
   // pipeline holds until it has been taken.
   rsp_fields_type skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (valid_ff[LAST] && !rsp_tready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_ff <= out_ff;
      end
   end

   assign rsp_tvalid = skid_valid_ff || valid_ff[LAST];
   assign rsp_tdata  = skid_valid_ff ? RSP_DATA_W'(skid_ff) : RSP_DATA_W'(out_ff);

   rsp_fields_type rsp_view;
   assign rsp_view = rsp_fields_type'(rsp_tdata);

   // A held pipeline keeps its valid bits.
   assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(valid_ff))
      else $error("valid bits moved while the pipeline was held");

   // The skid register fills only from a stalled last stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(valid_ff[LAST] && !rsp_tready))
      else $error("skid register filled without a stalled item");

   // The position fraction never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[SEL_STAGE] |-> (p9_ff <= ONE_FRAC))
      else $error("position fraction above one");

   // Wrapped angles stay in range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_view.out_bearing < BRG_W'(DEG360)))
      else $error("bearing out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_view.out_longitude <= DEG180)
                      && (rsp_view.out_longitude >= -DEG180)))
      else $error("longitude out of range");

endmodule

`default_nettype wire

[verif/cki_view_checker.sv]
// Checker for the camera keyframe interpolator: watches both stream channels,
// predicts every interpolated view and compares it field by field.
// Depends on cki_pkg for the item layouts and fixed-point constants.
module cki_view_checker
   import cki_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int unsigned           failures,
   output int unsigned           pending,
   output int unsigned           results_checked
);

   rsp_fields_type expected_views[$];
   rsp_fields_type want;
   rsp_fields_type got;

   // Quadratic ease-in-out of a saturated Q1.16 fraction.
   function automatic longint eased_fraction(input longint t);
      longint u;
      if (t < HALF_Q16) begin
         return (t * t + 16384) >> 15;
      end
      u = 2 * ONE_Q16 - 2 * t;
      return ONE_Q16 - ((u * u + 65536) >> 17);
   endfunction

   // Square root rounded to the nearest integer, built bit by bit.
   function automatic longint nearest_root(input longint x);
      longint r;
      longint c;
      r = 0;
      for (int b = 16; b >= 0; b--) begin
         c = r | (longint'(1) << b);
         if (c * c <= x) begin
            r = c;
         end
      end
      if (x - r * r > r) begin
         r++;
      end
      return r;
   endfunction

   // Step of delta scaled by a Q1.16 fraction, halves rounded towards plus infinity.
   function automatic longint q16_step(input longint delta, input longint frac);
      if (delta >= 0) begin
         return (delta * frac + 32768) >> 16;
      end
      return -(((-delta) * frac + 32767) >> 16);
   endfunction

   function automatic rsp_fields_type interpolate_camera(input req_fields_type k);
      longint f_lat, f_lon, f_brg, f_tilt, f_zoom;
      longint t_lat, t_lon, t_brg, t_tilt, t_zoom;
      longint t, e, p, zoom_step, span, lat, lon, brg, tilt, zoom;
      rsp_fields_type v;
      f_lat  = $signed(k.from_latitude);
      f_lon  = $signed(k.from_longitude);
      f_brg  = k.from_bearing;
      f_tilt = k.from_tilt;
      f_zoom = k.from_zoom;
      t_lat  = $signed(k.to_latitude);
      t_lon  = $signed(k.to_longitude);
      t_brg  = k.to_bearing;
      t_tilt = k.to_tilt;
      t_zoom = k.to_zoom;

      t = k.fraction;
      if (t > ONE_Q16) begin
         t = ONE_Q16;
      end
      e = eased_fraction(t);

      // Position follows a steeper curve once the zoom moves by more than a level.
      zoom_step = t_zoom - f_zoom;
      p = e;
      if (zoom_step > ONE_Q16) begin
         p = nearest_root(e << 16);
      end else if (zoom_step < -ONE_Q16) begin
         p = (e * e + 32768) >> 16;
      end

      lat = f_lat + q16_step(t_lat - f_lat, p);

      span = t_lon - f_lon;
      if (span > DEG180) begin
         span -= DEG360;
      end else if (span < -DEG180) begin
         span += DEG360;
      end
      lon = f_lon + q16_step(span, p);
      while (lon > DEG180) lon -= DEG360;
      while (lon < -DEG180) lon += DEG360;

      span = t_brg - f_brg;
      while (span > DEG180) span -= DEG360;
      while (span < -DEG180) span += DEG360;
      brg = f_brg + q16_step(span, e);
      while (brg >= DEG360) brg -= DEG360;
      while (brg < 0) brg += DEG360;

      tilt = f_tilt + q16_step(t_tilt - f_tilt, e);
      zoom = f_zoom + q16_step(zoom_step, e);

      v = '0;
      v.out_latitude  = lat[LAT_W-1:0];
      v.out_longitude = lon[LON_W-1:0];
      v.out_bearing   = brg[BRG_W-1:0];
      v.out_tilt      = tilt[TILT_W-1:0];
      v.out_zoom      = zoom[ZOOM_W-1:0];
      return v;
   endfunction

   task automatic flag_field(input string field, input logic [31:0] exp_value,
                             input logic [31:0] act_value);
      if (act_value !== exp_value) begin
         $display("%0t: %s mismatch, expected 0x%h, actual 0x%h",
                  $time, field, exp_value, act_value);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_views.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_views.size() == 0) begin
               $display("%0t: view item with none expected, actual 0x%h", $time, rsp_tdata);
               failures++;
            end else begin
               want = expected_views.pop_front();
               flag_field("out_latitude",  want.out_latitude,  got.out_latitude);
               flag_field("out_longitude", want.out_longitude, got.out_longitude);
               flag_field("out_bearing",   want.out_bearing,   got.out_bearing);
               flag_field("out_tilt",      want.out_tilt,      got.out_tilt);
               flag_field("out_zoom",      want.out_zoom,      got.out_zoom);
               results_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_views.push_back(interpolate_camera(req_fields_type'(req_tdata)));
         end
      end
      pending = expected_views.size();
   end

endmodule

[verif/tb_camera_keyframe_interpolator.sv]
// Testbench top for the camera keyframe interpolator: drives keyframe items,
// paces the view receiver and gives the verdict.
// Depends on cki_pkg, the block under test and cki_view_checker.
module tb_camera_keyframe_interpolator;
   import cki_pkg::*;

   localparam int CLOCK_PERIOD    = 8;
   localparam int RESET_CYCLES    = 12;
   localparam int DEGREE          = 65536;
   localparam int RANDOM_ITEMS    = 1930;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int DRAIN_CYCLES    = 64;
   localparam int CYCLE_LIMIT     = 1000000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int unsigned failures;
   int unsigned pending;
   int unsigned results_checked;
   int unsigned items_sent;
   int unsigned steady_items;
   int unsigned cycle_count;

   // Handshake between the stimulus and the receiver for the long output stall.
   bit hold_off_request;
   bit hold_off_active;

   // The clock toggles every half period for the whole run.
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   camera_keyframe_interpolator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // The checker sees exactly what the block sees, at the same rising edges,
   // and keeps its own queue of predicted views.
   cki_view_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .failures        (failures),
      .pending         (pending),
      .results_checked (results_checked)
   );

   // Watchdog: a hung handshake or a lost view ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Uniform pick in [lo, hi], signed bounds allowed.
   function automatic int span_pick(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // Builds an item from plain integers; each value is cut to its field width,
   // so -1 gives an all-ones field.
   function automatic req_fields_type make_keyframes(
      input int flat, input int flon, input int fbrg, input int ftilt, input int fzoom,
      input int tlat, input int tlon, input int tbrg, input int ttilt, input int tzoom,
      input int frac);
      req_fields_type kf;
      kf = '0;
      kf.from_latitude  = flat[LAT_W-1:0];
      kf.from_longitude = flon[LON_W-1:0];
      kf.from_bearing   = fbrg[BRG_W-1:0];
      kf.from_tilt      = ftilt[TILT_W-1:0];
      kf.from_zoom      = fzoom[ZOOM_W-1:0];
      kf.to_latitude    = tlat[LAT_W-1:0];
      kf.to_longitude   = tlon[LON_W-1:0];
      kf.to_bearing     = tbrg[BRG_W-1:0];
      kf.to_tilt        = ttilt[TILT_W-1:0];
      kf.to_zoom        = tzoom[ZOOM_W-1:0];
      kf.fraction       = frac[FRAC_W-1:0];
      return kf;
   endfunction

   // A longitude that often sits close to the antimeridian on either side.
   function automatic int pick_longitude();
      if ($urandom_range(0, 3) == 0) begin
         if ($urandom_range(0, 1) == 0) begin
            return span_pick(170 * DEGREE, DEG180);
         end
         return -span_pick(170 * DEGREE, DEG180);
      end
      return span_pick(-DEG180, DEG180);
   endfunction

   // Most items are well-formed keyframes with steered zoom steps and fractions;
   // the rest are raw bit patterns that reach every bit, out-of-range values too.
   function automatic req_fields_type random_keyframes();
      req_fields_type kf;
      int r;
      int zoom_from;
      int zoom_to;
      int frac;
      kf = '0;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         kf.from_latitude  = LAT_W'($urandom());
         kf.from_longitude = LON_W'($urandom());
         kf.from_bearing   = BRG_W'($urandom());
         kf.from_tilt      = TILT_W'($urandom());
         kf.from_zoom      = ZOOM_W'($urandom());
         kf.to_latitude    = LAT_W'($urandom());
         kf.to_longitude   = LON_W'($urandom());
         kf.to_bearing     = BRG_W'($urandom());
         kf.to_tilt        = TILT_W'($urandom());
         kf.to_zoom        = ZOOM_W'($urandom());
         kf.fraction       = FRAC_W'($urandom());
         return kf;
      end

      // Zoom steps land on and just beside the one-level threshold quite often.
      zoom_from = span_pick(0, 24 * ONE_Q16);
      case ($urandom_range(0, 5))
         0: zoom_to = zoom_from + ONE_Q16;
         1: zoom_to = zoom_from - ONE_Q16;
         2: zoom_to = zoom_from + ONE_Q16 + 1;
         3: zoom_to = zoom_from - ONE_Q16 - 1;
         default: zoom_to = span_pick(0, 24 * ONE_Q16);
      endcase

      r = $urandom_range(0, 99);
      if (r < 8) begin
         case ($urandom_range(0, 5))
            0: frac = 0;
            1: frac = 1;
            2: frac = HALF_Q16 - 1;
            3: frac = HALF_Q16;
            4: frac = ONE_Q16 - 1;
            default: frac = ONE_Q16;
         endcase
      end else if (r < 16) begin
         frac = span_pick(ONE_Q16 + 1, 131071);
      end else begin
         frac = span_pick(0, ONE_Q16);
      end

      return make_keyframes(
         span_pick(-90 * DEGREE, 90 * DEGREE), pick_longitude(), span_pick(0, DEG360 - 1),
         span_pick(0, 90 * DEGREE), zoom_from,
         span_pick(-90 * DEGREE, 90 * DEGREE), pick_longitude(), span_pick(0, DEG360 - 1),
         span_pick(0, 90 * DEGREE), zoom_to, frac);
   endfunction

   // Offers one item from a falling edge, holds it until the rising edge that
   // accepts it, then leaves a random gap. The valid is only lowered when a gap
   // follows, so it never gets two assignments in one time step.
   task automatic send_keyframes(input req_fields_type kf);
      int unsigned gap;
      int unsigned r;
      req_tdata  <= kf;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
      if (steady_items != 0) begin
         steady_items--;
         gap = 0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            steady_items = $urandom_range(30, 120);
         end
         if (r < 55) begin
            gap = 0;
         end else if (r < 90) begin
            gap = $urandom_range(1, 3);
         end else begin
            gap = $urandom_range(8, 30);
         end
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Receiver: alternates ready and stalled stretches, mostly short, now and then
   // long, with occasional long stretches of uninterrupted acceptance. On request
   // it stalls for a long stretch so that the pipeline and its
   // skid register fill and the block stops taking new items.
   initial begin : view_receiver
      int unsigned r;
      int unsigned len;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_off_active  = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_active = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               rsp_tready <= 1'b1;
               len = $urandom_range(1, 12);
            end else if (r < 58) begin
               rsp_tready <= 1'b1;
               len = $urandom_range(50, 200);
            end else if (r < 90) begin
               rsp_tready <= 1'b0;
               len = $urandom_range(1, 3);
            end else begin
               rsp_tready <= 1'b0;
               len = $urandom_range(10, 30);
            end
            repeat (len) @(negedge clock);
         end
      end
   end

   // Stimulus: reset, a directed set of corner cases, then the random stream,
   // then the drain and the verdict.
   initial begin : keyframe_stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Trivial item with all fields zero and the fraction at zero.
      send_keyframes(make_keyframes(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // Field extremes at full progress, then reversed with a saturated fraction.
      send_keyframes(make_keyframes(-90 * DEGREE, -DEG180, 0, 0, 0,
                                    90 * DEGREE, DEG180, DEG360 - 1, 90 * DEGREE,
                                    24 * ONE_Q16, ONE_Q16));
      send_keyframes(make_keyframes(90 * DEGREE, DEG180, DEG360 - 1, 90 * DEGREE,
                                    24 * ONE_Q16, -90 * DEGREE, -DEG180, 0, 0, 0, 131071));
      // A zoom change of exactly one level keeps the plain eased fraction,
      // either side of the midpoint of the ease curve.
      send_keyframes(make_keyframes(10 * DEGREE, 20 * DEGREE, 30 * DEGREE, 40 * DEGREE,
                                    5 * ONE_Q16, 20 * DEGREE, 40 * DEGREE, 60 * DEGREE,
                                    50 * DEGREE, 6 * ONE_Q16, HALF_Q16 - 1));
      send_keyframes(make_keyframes(10 * DEGREE, 20 * DEGREE, 30 * DEGREE, 40 * DEGREE,
                                    6 * ONE_Q16, 20 * DEGREE, 40 * DEGREE, 60 * DEGREE,
                                    50 * DEGREE, 5 * ONE_Q16, HALF_Q16));
      // Just over one level: square root when zooming in, square when zooming out.
      send_keyframes(make_keyframes(10 * DEGREE, 20 * DEGREE, 30 * DEGREE, 40 * DEGREE,
                                    5 * ONE_Q16, 20 * DEGREE, 40 * DEGREE, 60 * DEGREE,
                                    50 * DEGREE, 6 * ONE_Q16 + 1, 40000));
      send_keyframes(make_keyframes(10 * DEGREE, 20 * DEGREE, 30 * DEGREE, 40 * DEGREE,
                                    6 * ONE_Q16 + 1, 20 * DEGREE, 40 * DEGREE, 60 * DEGREE,
                                    50 * DEGREE, 5 * ONE_Q16, 40000));
      send_keyframes(make_keyframes(-45 * DEGREE, 5 * DEGREE, 0, 0, 0, 45 * DEGREE,
                                    -5 * DEGREE, 0, 0, 24 * ONE_Q16, 16384));
      send_keyframes(make_keyframes(-45 * DEGREE, 5 * DEGREE, 0, 0, 24 * ONE_Q16,
                                    45 * DEGREE, -5 * DEGREE, 0, 0, 0, 49152));
      // Longitudes exactly half a turn apart are kept, in both directions.
      send_keyframes(make_keyframes(0, -90 * DEGREE, 0, 0, 0, 0, 90 * DEGREE, 0, 0, 0, 1));
      send_keyframes(make_keyframes(0, 90 * DEGREE, 0, 0, 0, 0, -90 * DEGREE, 0, 0, 0,
                                    ONE_Q16 - 1));
      // Short way across the antimeridian, both directions.
      send_keyframes(make_keyframes(0, 170 * DEGREE, 0, 0, 0, 0, -170 * DEGREE, 0, 0, 0,
                                    49152));
      send_keyframes(make_keyframes(0, -170 * DEGREE, 0, 0, 0, 0, 170 * DEGREE, 0, 0, 0,
                                    16384));
      // Both endpoints of the longitude range are legal and stay as they are.
      send_keyframes(make_keyframes(0, DEG180, 0, 0, 0, 0, DEG180, 0, 0, 0, 30000));
      send_keyframes(make_keyframes(0, -DEG180, 0, 0, 0, 0, -DEG180, 0, 0, 0, 30000));
      // Bearing takes the shortest arc through north, and keeps a half turn.
      send_keyframes(make_keyframes(0, 0, 350 * DEGREE, 0, 0, 0, 0, 10 * DEGREE, 0, 0,
                                    HALF_Q16));
      send_keyframes(make_keyframes(0, 0, 10 * DEGREE, 0, 0, 0, 0, 350 * DEGREE, 0, 0,
                                    HALF_Q16));
      send_keyframes(make_keyframes(0, 0, 0, 0, 0, 0, 0, DEG180, 0, 0, ONE_Q16));
      send_keyframes(make_keyframes(0, 0, 270 * DEGREE, 0, 0, 0, 0, 90 * DEGREE, 0, 0,
                                    HALF_Q16));
      // Out-of-range patterns: all ones, then the most negative signed values
      // against the largest unsigned ones.
      send_keyframes(make_keyframes(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
      send_keyframes(make_keyframes(-(1 << 23), -(1 << 24), (1 << 25) - 1, (1 << 23) - 1,
                                    (1 << 21) - 1, (1 << 23) - 1, (1 << 24) - 1, 0, 0, 0,
                                    ONE_Q16 + 1));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 500) begin
            // Long output stall while items keep coming back to back. The item
            // just taken is withdrawn first so it is not offered twice.
            req_tvalid <= 1'b0;
            hold_off_request = 1'b1;
            while (!hold_off_active) @(negedge clock);
            steady_items = 64;
         end
         if (n % 640 == 639) begin
            // Pause the sender until every view in flight has come back.
            req_tvalid <= 1'b0;
            while (pending != 0) @(negedge clock);
         end
         send_keyframes(random_keyframes());
      end
      req_tvalid <= 1'b0;

      // Let the pipeline drain, then allow a margin for stray items.
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d keyframe pairs and checked %0d interpolated views.",
               items_sent, results_checked);
      $display("Run covered ease extremes, zoom curves, angle wrap and a long output stall.");
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
